### hdl/aei_pkg.sv
// Shared types and constants for the ANSI escape sequence interpreter.
package aei_pkg;

  localparam int COORD_W = 10;
  localparam int COLOR_W = 4;
  localparam int ACTION_W = 3;
  localparam int BYTE_W = 8;

  localparam logic [BYTE_W-1:0] CH_ESC = 8'h1B;
  localparam logic [BYTE_W-1:0] CH_CSI = 8'h5B;
  localparam logic [BYTE_W-1:0] CH_PRIVATE = 8'h3F;
  localparam logic [BYTE_W-1:0] CH_SEP = 8'h3B;
  localparam logic [BYTE_W-1:0] CH_DIGIT_LO = 8'h30;
  localparam logic [BYTE_W-1:0] CH_DIGIT_HI = 8'h39;
  localparam logic [BYTE_W-1:0] CH_FINAL_LO = 8'h40;
  localparam logic [BYTE_W-1:0] CH_FINAL_HI = 8'h7E;
  localparam logic [BYTE_W-1:0] CH_SGR = 8'h6D;
  localparam logic [BYTE_W-1:0] CH_CUP = 8'h48;
  localparam logic [BYTE_W-1:0] CH_CUU = 8'h41;
  localparam logic [BYTE_W-1:0] CH_CUD = 8'h42;
  localparam logic [BYTE_W-1:0] CH_CUF = 8'h43;
  localparam logic [BYTE_W-1:0] CH_CUB = 8'h44;
  localparam logic [BYTE_W-1:0] CH_CNL = 8'h45;
  localparam logic [BYTE_W-1:0] CH_CPL = 8'h46;
  localparam logic [BYTE_W-1:0] CH_ED = 8'h4A;
  localparam logic [BYTE_W-1:0] CH_DSR = 8'h6E;
  localparam logic [BYTE_W-1:0] CH_SET = 8'h68;
  localparam logic [BYTE_W-1:0] CH_RESET = 8'h6C;

  localparam int ED_ABOVE = 1;
  localparam int ED_ALL = 2;
  localparam int ED_ALL_SCROLL = 3;
  localparam int DSR_POSITION = 6;
  localparam int PRIV_CURSOR = 25;

  localparam int SGR_RESET = 0;
  localparam int SGR_FG_LO = 30;
  localparam int SGR_FG_HI = 37;
  localparam int SGR_FG_DEF = 39;
  localparam int SGR_BG_LO = 40;
  localparam int SGR_BG_HI = 47;
  localparam int SGR_BG_DEF = 49;
  localparam int SGR_FGB_LO = 90;
  localparam int SGR_FGB_HI = 97;
  localparam int SGR_FGB_OFS = 82;
  localparam int SGR_BGB_LO = 100;
  localparam int SGR_BGB_HI = 107;
  localparam int SGR_BGB_OFS = 92;

  localparam logic [COLOR_W-1:0] FG_DEFAULT = 4'd7;
  localparam logic [COLOR_W-1:0] BG_DEFAULT = 4'd0;
  localparam logic [COORD_W-1:0] COLS_DEFAULT = 10'd80;
  localparam logic [COORD_W-1:0] ROWS_DEFAULT = 10'd25;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_SGR,
    CMD_CUP,
    CMD_UP,
    CMD_DOWN,
    CMD_RIGHT,
    CMD_LEFT,
    CMD_NEXT_LINE,
    CMD_PREV_LINE,
    CMD_ERASE_ABOVE,
    CMD_ERASE_ALL,
    CMD_REPORT,
    CMD_SHOW,
    CMD_HIDE
  } cmd_op_e;

  typedef enum logic [ACTION_W-1:0] {
    ACT_NONE = 3'd0,
    ACT_UPDATED = 3'd1,
    ACT_ERASE_ABOVE = 3'd2,
    ACT_ERASE_ALL = 3'd3,
    ACT_REPORT = 3'd4
  } action_e;

  typedef struct packed {
    cmd_op_e op;
    logic has_p2;
  } cmd_t;

endpackage

### hdl/ansi_escape_interpreter.sv
// Top level of the ANSI escape sequence interpreter.
// Bytes of a terminal escape sequence enter on the seq_byte channel, one per
// transaction, and every byte produces exactly one result transaction that
// carries the action code and the cursor, color and visibility state after
// that byte. The parser classifies each byte in the cycle it is accepted and
// writes a command into a two-entry queue; the executor takes one command per
// cycle unless a receiver stall holds its output register, and holds its result in an output register.
// A byte is registered in the queue, then in the output register, before its
// result is valid; one byte per cycle is sustained while the receiver does
// not stall.
// When the receiver stalls, the output register holds its result, the queue
// fills, and seq_byte_stall_o rises once both queue entries are taken.
// Reset leaves no sequence open, the cursor at row 0 column 0, foreground 7,
// background 0, cursor shown, and the screen size at 80 columns by 25 rows.
// Screen size registers sit on the APB port at byte addresses 0 and 4; the user
// must write them only while no transaction is in flight, which is not enforced.
module ansi_escape_interpreter #(
  parameter int PARAM_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        seq_byte_valid_i,
  output logic        seq_byte_stall_o,
  input  logic [7:0]  seq_byte_i,
  output logic        result_valid_o,
  input  logic        result_stall_i,
  output logic [2:0]  action_o,
  output logic [9:0]  cursor_col_o,
  output logic [9:0]  cursor_row_o,
  output logic [3:0]  fg_index_o,
  output logic [3:0]  bg_index_o,
  output logic        cursor_visible_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import aei_pkg::*;

  localparam int QW = $bits(cmd_t) + 2 * PARAM_WIDTH;

  logic [COORD_W-1:0]     cols_q, rows_q;
  logic                   push, pop, q_full, q_empty;
  cmd_t                   f_cmd, b_cmd;
  logic [PARAM_WIDTH-1:0] f_p1, f_p2, b_p1, b_p2;
  logic [QW-1:0]          q_rdata;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'(rows_q) : 32'(cols_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= COLS_DEFAULT;
      rows_q <= ROWS_DEFAULT;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2]) begin
        rows_q <= pwdata[COORD_W-1:0];
      end else begin
        cols_q <= pwdata[COORD_W-1:0];
      end
    end
  end

  assign seq_byte_stall_o = q_full;

  aei_front #(
    .PW(PARAM_WIDTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (seq_byte_valid_i),
    .byte_i       (seq_byte_i),
    .queue_full_i (q_full),
    .push_o       (push),
    .cmd_o        (f_cmd),
    .p1_o         (f_p1),
    .p2_o         (f_p2)
  );

  aei_fifo #(
    .WIDTH(QW),
    .DEPTH(2)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i ({f_cmd, f_p1, f_p2}),
    .pop_i   (pop),
    .rdata_o (q_rdata),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  assign {b_cmd, b_p1, b_p2} = q_rdata;

  aei_back #(
    .PW(PARAM_WIDTH)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_avail_i      (!q_empty),
    .cmd_i            (b_cmd),
    .p1_i             (b_p1),
    .p2_i             (b_p2),
    .cols_i           (cols_q),
    .rows_i           (rows_q),
    .pop_o            (pop),
    .result_valid_o   (result_valid_o),
    .result_stall_i   (result_stall_i),
    .action_o         (action_o),
    .cursor_col_o     (cursor_col_o),
    .cursor_row_o     (cursor_row_o),
    .fg_index_o       (fg_index_o),
    .bg_index_o       (bg_index_o),
    .cursor_visible_o (cursor_visible_o)
  );

endmodule

### hdl/aei_front.sv
// Byte parser that gathers parameters and classifies each byte into a command.
module aei_front #(
  parameter int PW = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     byte_valid_i,
  input  logic [aei_pkg::BYTE_W-1:0] byte_i,
  input  logic                     queue_full_i,
  output logic                     push_o,
  output aei_pkg::cmd_t            cmd_o,
  output logic [PW-1:0]            p1_o,
  output logic [PW-1:0]            p2_o
);
  import aei_pkg::*;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_ESC = 2'd1;
  localparam logic [1:0] PH_BODY = 2'd2;
  localparam logic [PW-1:0] PMAX = '1;

  logic [1:0]    phase_q, phase_d;
  logic          priv_q, priv_d;
  logic [PW-1:0] p1_q, p1_d;
  logic [PW-1:0] p2_q, p2_d;
  logic [1:0]    cnt_q, cnt_d;
  logic [3:0]    digit;

  function automatic logic [PW-1:0] accumulate(input logic [PW-1:0] acc,
                                               input logic [3:0] d);
    logic [PW+3:0] v;
    begin
      v = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + (PW+4)'(d);
      accumulate = (v > (PW+4)'(PMAX)) ? PMAX : v[PW-1:0];
    end
  endfunction

  assign push_o = byte_valid_i && !queue_full_i;
  assign digit = 4'(byte_i - CH_DIGIT_LO);
  assign p1_o = p1_q;
  assign p2_o = p2_q;

  always_comb begin
    phase_d = phase_q;
    priv_d = priv_q;
    p1_d = p1_q;
    p2_d = p2_q;
    cnt_d = cnt_q;
    cmd_o.op = CMD_NONE;
    cmd_o.has_p2 = (cnt_q != 2'd0);
    if (byte_i == CH_ESC) begin
      phase_d = PH_ESC;
      priv_d = 1'b0;
      p1_d = '0;
      p2_d = '0;
      cnt_d = '0;
    end else if (phase_q == PH_ESC) begin
      if (byte_i == CH_CSI || byte_i == CH_PRIVATE) begin
        phase_d = PH_BODY;
        priv_d = (byte_i == CH_PRIVATE);
        p1_d = '0;
        p2_d = '0;
        cnt_d = '0;
      end else begin
        phase_d = PH_IDLE;
      end
    end else if (phase_q == PH_BODY) begin
      if (byte_i inside {[CH_DIGIT_LO:CH_DIGIT_HI]}) begin
        if (cnt_q == 2'd0) begin
          p1_d = accumulate(p1_q, digit);
        end else if (cnt_q == 2'd1) begin
          p2_d = accumulate(p2_q, digit);
        end
      end else if (byte_i == CH_SEP) begin
        if (cnt_q != 2'd3) begin
          cnt_d = cnt_q + 2'd1;
        end
      end else if (byte_i inside {[CH_FINAL_LO:CH_FINAL_HI]}) begin
        phase_d = PH_IDLE;
        if (priv_q) begin
          if (p1_q == PW'(PRIV_CURSOR) && byte_i == CH_SET) begin
            cmd_o.op = CMD_SHOW;
          end else if (p1_q == PW'(PRIV_CURSOR) && byte_i == CH_RESET) begin
            cmd_o.op = CMD_HIDE;
          end
        end else begin
          case (byte_i)
            CH_SGR: cmd_o.op = CMD_SGR;
            CH_CUP: cmd_o.op = CMD_CUP;
            CH_CUU: cmd_o.op = CMD_UP;
            CH_CUD: cmd_o.op = CMD_DOWN;
            CH_CUF: cmd_o.op = CMD_RIGHT;
            CH_CUB: cmd_o.op = CMD_LEFT;
            CH_CNL: cmd_o.op = CMD_NEXT_LINE;
            CH_CPL: cmd_o.op = CMD_PREV_LINE;
            CH_ED: begin
              if (p1_q == PW'(ED_ABOVE)) begin
                cmd_o.op = CMD_ERASE_ABOVE;
              end else if (p1_q == PW'(ED_ALL) || p1_q == PW'(ED_ALL_SCROLL)) begin
                cmd_o.op = CMD_ERASE_ALL;
              end
            end
            CH_DSR: begin
              if (p1_q == PW'(DSR_POSITION)) begin
                cmd_o.op = CMD_REPORT;
              end
            end
            default: cmd_o.op = CMD_NONE;
          endcase
        end
      end
    end else begin
      phase_d = PH_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      priv_q <= 1'b0;
      p1_q <= '0;
      p2_q <= '0;
      cnt_q <= '0;
    end else if (push_o) begin
      phase_q <= phase_d;
      priv_q <= priv_d;
      p1_q <= p1_d;
      p2_q <= p2_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

### hdl/aei_fifo.sv
// Small command queue between the parser and the executor.
module aei_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wptr_q, rptr_q;
  logic [CW-1:0]    count_q;

  assign full_o = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + AW'(1);
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + AW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

endmodule

### hdl/aei_back.sv
// Executor that applies commands to the cursor, color and visibility registers.
module aei_back #(
  parameter int PW = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cmd_avail_i,
  input  aei_pkg::cmd_t                cmd_i,
  input  logic [PW-1:0]                p1_i,
  input  logic [PW-1:0]                p2_i,
  input  logic [aei_pkg::COORD_W-1:0]  cols_i,
  input  logic [aei_pkg::COORD_W-1:0]  rows_i,
  output logic                         pop_o,
  output logic                         result_valid_o,
  input  logic                         result_stall_i,
  output logic [aei_pkg::ACTION_W-1:0] action_o,
  output logic [aei_pkg::COORD_W-1:0]  cursor_col_o,
  output logic [aei_pkg::COORD_W-1:0]  cursor_row_o,
  output logic [aei_pkg::COLOR_W-1:0]  fg_index_o,
  output logic [aei_pkg::COLOR_W-1:0]  bg_index_o,
  output logic                         cursor_visible_o
);
  import aei_pkg::*;

  localparam int VW = ((PW > COORD_W) ? PW : COORD_W) + 1;

  logic                valid_q;
  logic [ACTION_W-1:0] act_q, act_d;
  logic [COORD_W-1:0]  col_q, col_d, row_q, row_d;
  logic [COLOR_W-1:0]  fg_q, fg_d, bg_q, bg_d;
  logic                vis_q, vis_d;
  logic [VW-1:0]       cnt, row_x, col_x, p1_x, p2_x;
  logic [2*COLOR_W-1:0] colors1, colors2;

  function automatic logic [COORD_W-1:0] clamp(input logic [VW-1:0] v,
                                               input logic [COORD_W-1:0] lim);
    logic [COORD_W-1:0] hi;
    begin
      hi = (lim == '0) ? '0 : lim - COORD_W'(1);
      clamp = (v > VW'(hi)) ? hi : v[COORD_W-1:0];
    end
  endfunction

  function automatic logic [2*COLOR_W-1:0] sgr(input logic [PW-1:0] n,
                                               input logic [2*COLOR_W-1:0] c);
    logic [COLOR_W-1:0] f, b;
    begin
      f = c[2*COLOR_W-1:COLOR_W];
      b = c[COLOR_W-1:0];
      if (n == PW'(SGR_RESET)) begin
        f = FG_DEFAULT;
        b = BG_DEFAULT;
      end else if (n >= PW'(SGR_FG_LO) && n <= PW'(SGR_FG_HI)) begin
        f = COLOR_W'(n - PW'(SGR_FG_LO));
      end else if (n >= PW'(SGR_BG_LO) && n <= PW'(SGR_BG_HI)) begin
        b = COLOR_W'(n - PW'(SGR_BG_LO));
      end else if (n >= PW'(SGR_FGB_LO) && n <= PW'(SGR_FGB_HI)) begin
        f = COLOR_W'(n - PW'(SGR_FGB_OFS));
      end else if (n >= PW'(SGR_BGB_LO) && n <= PW'(SGR_BGB_HI)) begin
        b = COLOR_W'(n - PW'(SGR_BGB_OFS));
      end else if (n == PW'(SGR_FG_DEF)) begin
        f = FG_DEFAULT;
      end else if (n == PW'(SGR_BG_DEF)) begin
        b = BG_DEFAULT;
      end
      sgr = {f, b};
    end
  endfunction

  assign pop_o = cmd_avail_i && (!valid_q || !result_stall_i);
  assign result_valid_o = valid_q;
  assign action_o = act_q;
  assign cursor_col_o = col_q;
  assign cursor_row_o = row_q;
  assign fg_index_o = fg_q;
  assign bg_index_o = bg_q;
  assign cursor_visible_o = vis_q;

  assign p1_x = VW'(p1_i);
  assign p2_x = VW'(p2_i);
  assign row_x = VW'(row_q);
  assign col_x = VW'(col_q);
  assign cnt = (p1_i == '0) ? VW'(1) : p1_x;
  assign colors1 = sgr(p1_i, {fg_q, bg_q});
  assign colors2 = cmd_i.has_p2 ? sgr(p2_i, colors1) : colors1;

  always_comb begin
    act_d = ACT_UPDATED;
    col_d = col_q;
    row_d = row_q;
    fg_d = fg_q;
    bg_d = bg_q;
    vis_d = vis_q;
    case (cmd_i.op)
      CMD_SGR: begin
        fg_d = colors2[2*COLOR_W-1:COLOR_W];
        bg_d = colors2[COLOR_W-1:0];
      end
      CMD_CUP: begin
        row_d = clamp((p1_i == '0) ? '0 : p1_x - VW'(1), rows_i);
        col_d = clamp((cmd_i.has_p2 && p2_i != '0) ? p2_x - VW'(1) : '0, cols_i);
      end
      CMD_UP: begin
        row_d = clamp((cnt > row_x) ? '0 : row_x - cnt, rows_i);
        col_d = clamp(col_x, cols_i);
      end
      CMD_DOWN: begin
        row_d = clamp(row_x + cnt, rows_i);
        col_d = clamp(col_x, cols_i);
      end
      CMD_RIGHT: begin
        row_d = clamp(row_x, rows_i);
        col_d = clamp(col_x + cnt, cols_i);
      end
      CMD_LEFT: begin
        row_d = clamp(row_x, rows_i);
        col_d = clamp((cnt > col_x) ? '0 : col_x - cnt, cols_i);
      end
      CMD_NEXT_LINE: begin
        row_d = clamp(row_x + cnt, rows_i);
        col_d = '0;
      end
      CMD_PREV_LINE: begin
        row_d = clamp((cnt > row_x) ? '0 : row_x - cnt, rows_i);
        col_d = '0;
      end
      CMD_ERASE_ABOVE: act_d = ACT_ERASE_ABOVE;
      CMD_ERASE_ALL: act_d = ACT_ERASE_ALL;
      CMD_REPORT: act_d = ACT_REPORT;
      CMD_SHOW: vis_d = 1'b1;
      CMD_HIDE: vis_d = 1'b0;
      default: act_d = ACT_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      act_q <= ACT_NONE;
      col_q <= '0;
      row_q <= '0;
      fg_q <= FG_DEFAULT;
      bg_q <= BG_DEFAULT;
      vis_q <= 1'b1;
    end else if (pop_o) begin
      valid_q <= 1'b1;
      act_q <= act_d;
      col_q <= col_d;
      row_q <= row_d;
      fg_q <= fg_d;
      bg_q <= bg_d;
      vis_q <= vis_d;
    end else if (!result_stall_i) begin
      valid_q <= 1'b0;
    end
  end

endmodule

### tb/sv/tb_top.sv
// Self-checking testbench for the ANSI escape sequence interpreter with a built-in screen model.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import aei_pkg::*;

  localparam int PW = 16;
  localparam int unsigned PARAM_MAX = (1 << PW) - 1;
  localparam int MAX_WAIT = 18;
  localparam int LONG_HOLD = 80;
  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_BYTES = 75;
  localparam int EMPTY = -1;
  localparam logic [2:0] ADDR_COLUMNS = 3'd0;
  localparam logic [2:0] ADDR_ROWS = 3'd4;

  typedef enum logic [1:0] {SEQ_IDLE, SEQ_ESC, SEQ_BODY} seq_phase_e;

  typedef struct packed {
    action_e act;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [COLOR_W-1:0] fg;
    logic [COLOR_W-1:0] bg;
    logic vis;
  } screen_t;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic seq_byte_valid_i = 1'b0;
  logic seq_byte_stall_o;
  logic [7:0] seq_byte_i = '0;
  logic result_valid_o;
  logic result_stall_i = 1'b0;
  logic [2:0] action_o;
  logic [9:0] cursor_col_o;
  logic [9:0] cursor_row_o;
  logic [3:0] fg_index_o;
  logic [3:0] bg_index_o;
  logic cursor_visible_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  ansi_escape_interpreter #(.PARAM_WIDTH(PW)) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .seq_byte_valid_i(seq_byte_valid_i),
    .seq_byte_stall_o(seq_byte_stall_o),
    .seq_byte_i(seq_byte_i),
    .result_valid_o(result_valid_o),
    .result_stall_i(result_stall_i),
    .action_o(action_o),
    .cursor_col_o(cursor_col_o),
    .cursor_row_o(cursor_row_o),
    .fg_index_o(fg_index_o),
    .bg_index_o(bg_index_o),
    .cursor_visible_o(cursor_visible_o),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  seq_phase_e phase_q = SEQ_IDLE;
  logic priv_q = 1'b0;
  int unsigned p1_q = 0;
  int unsigned p2_q = 0;
  int unsigned sep_count = 0;
  int col_q = 0;
  int row_q = 0;
  logic [COLOR_W-1:0] fg_q = FG_DEFAULT;
  logic [COLOR_W-1:0] bg_q = BG_DEFAULT;
  logic vis_q = 1'b1;
  int model_columns = COLS_DEFAULT;
  int model_rows = ROWS_DEFAULT;

  screen_t expected_screens[$];
  logic [7:0] pending_bytes[$];
  screen_t next_screen;
  int error_count = 0;
  int send_wait = 0;
  int recv_wait = 0;
  int idle_cycles = 0;
  bit send_idle_on = 1'b0;
  bit recv_idle_on = 1'b0;
  bit long_hold_go = 1'b0;
  bit long_hold_taken = 1'b0;

  logic [7:0] command_finals [12] = '{CH_SGR, CH_CUP, CH_CUU, CH_CUD, CH_CUF, CH_CUB,
                                      CH_CNL, CH_CPL, CH_ED, CH_DSR, CH_SET, CH_RESET};

  function automatic void clear_params();
    p1_q = 0;
    p2_q = 0;
    sep_count = 0;
  endfunction

  function automatic int unsigned add_digit(int unsigned acc, logic [7:0] b);
    int unsigned v;
    v = acc * 10 + int'(b - CH_DIGIT_LO);
    return (v > PARAM_MAX) ? PARAM_MAX : v;
  endfunction

  function automatic int clamp_coord(int v, int count);
    int hi;
    hi = (count != 0) ? count - 1 : 0;
    if (v < 0) return 0;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void move_to(int r, int c);
    row_q = clamp_coord(r, model_rows);
    col_q = clamp_coord(c, model_columns);
  endfunction

  function automatic void apply_sgr_code(int unsigned n);
    if (n == SGR_RESET) begin
      fg_q = FG_DEFAULT;
      bg_q = BG_DEFAULT;
    end else if (n >= SGR_FG_LO && n <= SGR_FG_HI) begin
      fg_q = COLOR_W'(n - SGR_FG_LO);
    end else if (n >= SGR_BG_LO && n <= SGR_BG_HI) begin
      bg_q = COLOR_W'(n - SGR_BG_LO);
    end else if (n >= SGR_FGB_LO && n <= SGR_FGB_HI) begin
      fg_q = COLOR_W'(n - SGR_FGB_OFS);
    end else if (n >= SGR_BGB_LO && n <= SGR_BGB_HI) begin
      bg_q = COLOR_W'(n - SGR_BGB_OFS);
    end else if (n == SGR_FG_DEF) begin
      fg_q = FG_DEFAULT;
    end else if (n == SGR_BG_DEF) begin
      bg_q = BG_DEFAULT;
    end
  endfunction

  function automatic action_e run_command(logic [7:0] fin);
    int cnt;
    cnt = (p1_q != 0) ? int'(p1_q) : 1;
    if (priv_q) begin
      if (p1_q == PRIV_CURSOR && (fin == CH_SET || fin == CH_RESET)) begin
        vis_q = (fin == CH_SET);
        return ACT_UPDATED;
      end
      return ACT_NONE;
    end
    case (fin)
      CH_SGR: begin
        apply_sgr_code(p1_q);
        if (sep_count >= 1) apply_sgr_code(p2_q);
        return ACT_UPDATED;
      end
      CH_CUP: begin
        move_to((p1_q != 0) ? int'(p1_q) - 1 : 0,
                (sep_count >= 1 && p2_q != 0) ? int'(p2_q) - 1 : 0);
        return ACT_UPDATED;
      end
      CH_CUU: begin
        move_to(row_q - cnt, col_q);
        return ACT_UPDATED;
      end
      CH_CUD: begin
        move_to(row_q + cnt, col_q);
        return ACT_UPDATED;
      end
      CH_CUF: begin
        move_to(row_q, col_q + cnt);
        return ACT_UPDATED;
      end
      CH_CUB: begin
        move_to(row_q, col_q - cnt);
        return ACT_UPDATED;
      end
      CH_CNL: begin
        move_to(row_q + cnt, 0);
        return ACT_UPDATED;
      end
      CH_CPL: begin
        move_to(row_q - cnt, 0);
        return ACT_UPDATED;
      end
      CH_ED: begin
        if (p1_q == ED_ABOVE) return ACT_ERASE_ABOVE;
        if (p1_q == ED_ALL || p1_q == ED_ALL_SCROLL) return ACT_ERASE_ALL;
        return ACT_NONE;
      end
      CH_DSR: begin
        return (p1_q == DSR_POSITION) ? ACT_REPORT : ACT_NONE;
      end
      default: begin
        return ACT_NONE;
      end
    endcase
  endfunction

  function automatic void apply_escape_byte(logic [7:0] b);
    action_e act;
    act = ACT_NONE;
    if (b == CH_ESC) begin
      phase_q = SEQ_ESC;
      priv_q = 1'b0;
      clear_params();
    end else if (phase_q == SEQ_ESC) begin
      if (b == CH_CSI || b == CH_PRIVATE) begin
        phase_q = SEQ_BODY;
        priv_q = (b == CH_PRIVATE);
        clear_params();
      end else begin
        phase_q = SEQ_IDLE;
      end
    end else if (phase_q == SEQ_BODY) begin
      if (b >= CH_DIGIT_LO && b <= CH_DIGIT_HI) begin
        if (sep_count == 0) p1_q = add_digit(p1_q, b);
        else if (sep_count == 1) p2_q = add_digit(p2_q, b);
      end else if (b == CH_SEP) begin
        if (sep_count < 3) sep_count++;
      end else if (b >= CH_FINAL_LO && b <= CH_FINAL_HI) begin
        act = run_command(b);
        phase_q = SEQ_IDLE;
      end
    end else begin
      phase_q = SEQ_IDLE;
    end
    expected_screens.push_back('{act, COORD_W'(col_q), COORD_W'(row_q), fg_q, bg_q, vis_q});
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endfunction

  function automatic int draw_wait(bit enabled);
    if (!enabled || $urandom_range(0, 2) != 0) return 0;
    return $urandom_range(1, MAX_WAIT);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_byte_valid_i <= 1'b0;
      seq_byte_i <= '0;
      send_wait <= 0;
    end else begin
      if (seq_byte_valid_i && !seq_byte_stall_o) apply_escape_byte(seq_byte_i);
      if (!seq_byte_valid_i || !seq_byte_stall_o) begin
        if (send_wait != 0) begin
          send_wait <= send_wait - 1;
          seq_byte_valid_i <= 1'b0;
        end else if (pending_bytes.size() != 0) begin
          seq_byte_i <= pending_bytes.pop_front();
          seq_byte_valid_i <= 1'b1;
          send_wait <= draw_wait(send_idle_on);
        end else begin
          seq_byte_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_stall_i <= 1'b0;
      recv_wait = 0;
    end else begin
      if (result_valid_o && !result_stall_i) begin
        if (expected_screens.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual action %0d", $time, action_o);
          error_count++;
        end else begin
          next_screen = expected_screens.pop_front();
          check_field("action", next_screen.act, action_o);
          check_field("cursor_col", next_screen.col, cursor_col_o);
          check_field("cursor_row", next_screen.row, cursor_row_o);
          check_field("fg_index", next_screen.fg, fg_index_o);
          check_field("bg_index", next_screen.bg, bg_index_o);
          check_field("cursor_visible", next_screen.vis, cursor_visible_o);
        end
      end
      if (long_hold_go && !long_hold_taken) begin
        long_hold_taken = 1'b1;
        recv_wait = LONG_HOLD;
      end else if (result_valid_o && !result_stall_i) begin
        recv_wait = draw_wait(recv_idle_on);
      end else if (recv_wait != 0) begin
        recv_wait--;
      end
      result_stall_i <= (recv_wait != 0);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((seq_byte_valid_i && !seq_byte_stall_o) || (result_valid_o && !result_stall_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic push_number(int unsigned n);
    string digits;
    digits = $sformatf("%0d", n);
    for (int i = 0; i < digits.len(); i++) pending_bytes.push_back(digits[i]);
  endtask

  task automatic push_sequence(logic [7:0] intro, int p0, int p1, int p2, int count,
                               logic [7:0] fin, bit noisy);
    int params[3];
    int noise_at;
    logic [7:0] junk;
    params = '{p0, p1, p2};
    noise_at = $urandom_range(0, count);
    pending_bytes.push_back(CH_ESC);
    pending_bytes.push_back(intro);
    for (int i = 0; i <= count; i++) begin
      if (noisy && i == noise_at) begin
        do junk = 8'($urandom_range(0, 8'h3F));
        while ((junk >= CH_DIGIT_LO && junk <= CH_DIGIT_HI) || junk == CH_SEP || junk == CH_ESC);
        pending_bytes.push_back(junk);
      end
      if (i < count) begin
        if (i > 0) pending_bytes.push_back(CH_SEP);
        if (params[i] != EMPTY) push_number(params[i]);
      end
    end
    pending_bytes.push_back(fin);
  endtask

  function automatic int sgr_code();
    case ($urandom_range(0, 7))
      0: return SGR_RESET;
      1: return SGR_FG_LO + $urandom_range(0, 7);
      2: return SGR_BG_LO + $urandom_range(0, 7);
      3: return SGR_FGB_LO + $urandom_range(0, 7);
      4: return SGR_BGB_LO + $urandom_range(0, 7);
      5: return SGR_FG_DEF;
      6: return SGR_BG_DEF;
      default: return $urandom_range(0, 120);
    endcase
  endfunction

  function automatic int pick_param(logic [7:0] fin);
    case ($urandom_range(0, 9))
      0: return EMPTY;
      1: return $urandom_range(0, 99999);
      2, 3: return $urandom_range(0, 1100);
      default: begin
        case (fin)
          CH_SGR: return sgr_code();
          CH_ED: return $urandom_range(0, 4);
          CH_DSR: return $urandom_range(5, 7);
          CH_SET, CH_RESET: return PRIV_CURSOR;
          default: return $urandom_range(0, 30);
        endcase
      end
    endcase
  endfunction

  task automatic push_random_sequence();
    int kind;
    int count;
    logic [7:0] intro;
    logic [7:0] fin;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      repeat ($urandom_range(1, 4)) pending_bytes.push_back(8'($urandom_range(0, 255)));
    end else if (kind == 1) begin
      // A sequence cut short; the next ESC restarts parsing.
      pending_bytes.push_back(CH_ESC);
      if ($urandom_range(0, 1)) pending_bytes.push_back(CH_CSI);
      if ($urandom_range(0, 1)) push_number($urandom_range(0, 500));
    end else begin
      intro = ($urandom_range(0, 4) == 0) ? CH_PRIVATE : CH_CSI;
      if ($urandom_range(0, 7) == 0) fin = 8'($urandom_range(CH_FINAL_LO, CH_FINAL_HI));
      else if (intro == CH_PRIVATE && $urandom_range(0, 3) != 0)
        fin = $urandom_range(0, 1) ? CH_SET : CH_RESET;
      else fin = command_finals[$urandom_range(0, 11)];
      count = $urandom_range(0, 3);
      push_sequence(intro, pick_param(fin), pick_param(fin), pick_param(fin), count, fin,
                    $urandom_range(0, 7) == 0);
    end
  endtask

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i);
    while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_bytes.size() != 0 || seq_byte_valid_i || expected_screens.size() != 0);
  endtask

  task automatic set_screen(int columns, int rows);
    apb_write(ADDR_COLUMNS, columns);
    apb_write(ADDR_ROWS, rows);
    model_columns = columns;
    model_rows = rows;
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Stray bytes, a dropped ESC, saturation with an empty and a surplus parameter,
    // hiding the cursor, a default move count, ESC restarting an open sequence and a two-code bright SGR.
    pending_bytes.push_back(8'hFF);
    pending_bytes.push_back(8'h00);
    pending_bytes.push_back(CH_ESC);
    pending_bytes.push_back(CH_CUU);
    push_sequence(CH_CSI, 99999, EMPTY, 7, 3, CH_CUP, 1'b0);
    push_sequence(CH_PRIVATE, PRIV_CURSOR, 0, 0, 1, CH_RESET, 1'b0);
    push_sequence(CH_CSI, 0, 0, 0, 0, CH_CUU, 1'b0);
    pending_bytes.push_back(CH_ESC);
    pending_bytes.push_back(CH_CSI);
    push_sequence(CH_CSI, SGR_FGB_HI, SGR_BGB_HI, 0, 2, CH_SGR, 1'b0);

    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) begin
        wait_drained();
        repeat (2) @(negedge clk_i);
        case (ph)
          1: set_screen(1, 1);
          2: set_screen(1023, 1023);
          3: set_screen(1023, 1);
          4: set_screen($urandom_range(1, 1023), $urandom_range(1, 1023));
          default: set_screen(COLS_DEFAULT, ROWS_DEFAULT);
        endcase
        @(negedge clk_i);
      end
      send_idle_on = (ph != 0 && ph != 3);
      recv_idle_on = (ph == 1 || ph == 2 || ph == 5);
      if (ph == 3) long_hold_go = 1'b1;
      while (pending_bytes.size() < PHASE_BYTES) push_random_sequence();
    end

    wait_drained();
    repeat (4) @(posedge clk_i);
    if (error_count == 0 && expected_screens.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
